FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared widths, register map and cell types of the sorted cell chain.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX    = 64;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int AGE_WIDTH     = $clog2(WINDOW_MAX);
   localparam int COUNT_WIDTH   = $clog2(WINDOW_MAX + 1);
   localparam int LENGTH_WIDTH  = 7;
   localparam int CMP_WIDTH     = (COUNT_WIDTH > LENGTH_WIDTH) ? COUNT_WIDTH : LENGTH_WIDTH;
   localparam int ADDR_WIDTH    = 3;
   localparam int DATA_WIDTH    = 32;

   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = LENGTH_WIDTH'(5);
   localparam logic [CMP_WIDTH-1:0]    LENGTH_MIN   = CMP_WIDTH'(2);
   localparam logic [CMP_WIDTH-1:0]    LENGTH_MAX   = CMP_WIDTH'(WINDOW_MAX);

   // Register index, taken from paddr[2].
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic [AGE_WIDTH-1:0]           age;
   } entry_type;

   typedef struct packed {
      logic                           load;
      logic                           full;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [AGE_WIDTH-1:0]           last_age;
   } cell_ctl_type;

endpackage

FILE: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window median sort cell
// Holds one sorted entry. In one update the oldest entry leaves the chain,
// the entries above it close the gap and the new sample drops into place.
// ----------------------------------------------------------------------------
module swm_cell (
   input  logic                                    clock,
   input  swm_pkg::cell_ctl_type                   ctl,
   input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] old_value,
   input  logic                                    valid,
   input  swm_pkg::entry_type                      next_entry,
   input  logic                                    next_gt,
   input  swm_pkg::entry_type                      prev_cmp_entry,
   input  logic                                    prev_cmp_gt,
   output swm_pkg::entry_type                      entry,
   output logic                                    gt,
   output swm_pkg::entry_type                      cmp_entry,
   output logic                                    cmp_gt,
   output logic                                    oldest
);

   swm_pkg::entry_type entry_ff;
   swm_pkg::entry_type entry_in;
   logic               shifted;

   always_comb begin
      gt      = !valid || (entry_ff.value > ctl.sample);
      shifted = ctl.full && (!valid || (entry_ff.value >= old_value));
      oldest  = valid && (entry_ff.age == ctl.last_age);
      if (shifted) begin
         cmp_entry = next_entry;
         cmp_gt    = next_gt;
      end else begin
         cmp_entry = entry_ff;
         cmp_gt    = gt;
      end
      if (!cmp_gt) begin
         entry_in.value = cmp_entry.value;
         entry_in.age   = cmp_entry.age + swm_pkg::AGE_WIDTH'(1);
      end else if (!prev_cmp_gt) begin
         entry_in.value = ctl.sample;
         entry_in.age   = '0;
      end else begin
         entry_in.value = prev_cmp_entry.value;
         entry_in.age   = prev_cmp_entry.age + swm_pkg::AGE_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/swm_median.sv
// ----------------------------------------------------------------------------
// Sliding window median output pipeline
// Picks the middle entries of the updated chain, averages them for an even
// count and holds the result until the transfer on the result channel.
// ----------------------------------------------------------------------------
module swm_median (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  start,
   input  logic [swm_pkg::COUNT_WIDTH-1:0]                       count,
   input  logic [swm_pkg::WINDOW_MAX-1:0][swm_pkg::SAMPLE_WIDTH-1:0] values,
   output logic                                                  ready,
   output logic                                                  rsp_tvalid,
   input  logic                                                  rsp_tready,
   output logic [swm_pkg::SAMPLE_WIDTH-1:0]                      rsp_tdata
);

   logic                                pend_valid_ff;
   logic [swm_pkg::COUNT_WIDTH-1:0]     pend_count_ff;
   logic                                sel_valid_ff;
   logic                                odd_ff;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    lo_ff;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    hi_ff;
   logic                                out_valid_ff;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    out_data_ff;

   logic                                out_en;
   logic                                sel_en;
   logic [swm_pkg::COUNT_WIDTH-1:0]     half;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    lo_in;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    hi_in;
   logic [swm_pkg::SAMPLE_WIDTH:0]      sum;
   logic [swm_pkg::SAMPLE_WIDTH:0]      sum_adj;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    out_data_in;

   assign out_en = !out_valid_ff || rsp_tready;
   assign sel_en = !sel_valid_ff || out_en;
   assign ready  = !pend_valid_ff || sel_en;
   assign half   = pend_count_ff >> 1;

   always_comb begin
      lo_in = '0;
      hi_in = '0;
      for (int k = 0; k < swm_pkg::WINDOW_MAX; k++) begin
         if (half == swm_pkg::COUNT_WIDTH'(k)) begin
            hi_in = hi_in | values[k];
         end
         if (half == swm_pkg::COUNT_WIDTH'(k + 1)) begin
            lo_in = lo_in | values[k];
         end
      end
   end

   always_comb begin
      sum     = {lo_ff[swm_pkg::SAMPLE_WIDTH-1], lo_ff} + {hi_ff[swm_pkg::SAMPLE_WIDTH-1], hi_ff};
      sum_adj = sum + {{swm_pkg::SAMPLE_WIDTH{1'b0}}, sum[swm_pkg::SAMPLE_WIDTH] & sum[0]};
      if (odd_ff) begin
         out_data_in = hi_ff;
      end else begin
         out_data_in = sum_adj[swm_pkg::SAMPLE_WIDTH:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         sel_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (ready) begin
            pend_valid_ff <= start;
         end
         if (sel_en) begin
            sel_valid_ff <= pend_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= sel_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready && start) begin
         pend_count_ff <= count;
      end
      if (sel_en && pend_valid_ff) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         odd_ff <= pend_count_ff[0];
      end
      if (out_en && sel_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: rtl/sliding_window_median_unit.sv
// ----------------------------------------------------------------------------
// Sliding window median unit
// Running median over the most recent samples, kept in a sorted cell chain.
// ----------------------------------------------------------------------------
// One signed sample goes in per transfer and one median comes out per transfer.
// The unit takes a new sample every clock cycle while its pipeline can move. The
// chain update happens at the sample's transfer; the middle-entry select and the
// averaging register follow, and a stalled result channel holds the input back
// only once the three pipeline stages are full.
// The window length register clears the window when written, so the following
// median is that of the new sample alone; lengths below two count as two and
// above 64 as 64. While the window fills, the median is taken over the samples
// seen so far, and an even count gives the mean of the two middle samples
// truncated toward zero.
module sliding_window_median_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [swm_pkg::SAMPLE_WIDTH-1:0]     req_tdata,   // [15:0] sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swm_pkg::SAMPLE_WIDTH-1:0]     rsp_tdata,   // [15:0] median
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [swm_pkg::ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [swm_pkg::DATA_WIDTH-1:0]       csr_pwdata,
   output logic [swm_pkg::DATA_WIDTH-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   logic [swm_pkg::LENGTH_WIDTH-1:0]   window_ff;
   logic [swm_pkg::COUNT_WIDTH-1:0]    fill_ff;
   logic [swm_pkg::COUNT_WIDTH-1:0]    fill_in;

   logic                               csr_write;
   logic                               accept;
   logic [swm_pkg::CMP_WIDTH-1:0]      window_ext;
   logic [swm_pkg::CMP_WIDTH-1:0]      window_eff;
   logic                               full;
   swm_pkg::cell_ctl_type              ctl;
   logic signed [swm_pkg::SAMPLE_WIDTH-1:0] old_value;

   swm_pkg::entry_type                 cell_entry [swm_pkg::WINDOW_MAX];
   swm_pkg::entry_type                 cell_cmp   [swm_pkg::WINDOW_MAX];
   logic [swm_pkg::WINDOW_MAX-1:0]     cell_gt;
   logic [swm_pkg::WINDOW_MAX-1:0]     cell_cmp_gt;
   logic [swm_pkg::WINDOW_MAX-1:0]     cell_valid;
   logic [swm_pkg::WINDOW_MAX-1:0]     cell_oldest;
   logic [swm_pkg::WINDOW_MAX-1:0][swm_pkg::SAMPLE_WIDTH-1:0] median_values;
   logic [swm_pkg::WINDOW_MAX-1:0]     sorted_ok;
   logic [swm_pkg::WINDOW_MAX-1:0]     newest;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == swm_pkg::REG_WINDOW_LENGTH) ?
                       swm_pkg::DATA_WIDTH'(window_ff) : '0;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      window_ext = swm_pkg::CMP_WIDTH'(window_ff);
      if (window_ext < swm_pkg::LENGTH_MIN) begin
         window_eff = swm_pkg::LENGTH_MIN;
      end else if (window_ext > swm_pkg::LENGTH_MAX) begin
         window_eff = swm_pkg::LENGTH_MAX;
      end else begin
         window_eff = window_ext;
      end
      full = swm_pkg::CMP_WIDTH'(fill_ff) >= window_eff;
      if (full) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + swm_pkg::COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= swm_pkg::LENGTH_RESET;
         fill_ff   <= '0;
      end else if (csr_write && csr_paddr[2] == swm_pkg::REG_WINDOW_LENGTH) begin
         window_ff <= csr_pwdata[swm_pkg::LENGTH_WIDTH-1:0];
         fill_ff   <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_comb begin
      ctl.load     = accept;
      ctl.full     = full;
      ctl.sample   = req_tdata;
      ctl.last_age = swm_pkg::AGE_WIDTH'(fill_ff - swm_pkg::COUNT_WIDTH'(1));
      old_value    = '0;
      for (int k = 0; k < swm_pkg::WINDOW_MAX; k++) begin
         cell_valid[k] = swm_pkg::COUNT_WIDTH'(k) < fill_ff;
         if (cell_oldest[k]) begin
            old_value = old_value | cell_entry[k].value;
         end
      end
   end

   for (genvar k = 0; k < swm_pkg::WINDOW_MAX; k++) begin : g_cell
      swm_pkg::entry_type next_entry;
      logic               next_gt;
      swm_pkg::entry_type prev_cmp_entry;
      logic               prev_cmp_gt;

      if (k == swm_pkg::WINDOW_MAX - 1) begin : g_last
         assign next_entry = '0;
         assign next_gt    = 1'b1;
      end else begin : g_inner
         assign next_entry = cell_entry[k+1];
         assign next_gt    = cell_gt[k+1];
      end

      if (k == 0) begin : g_first
         assign prev_cmp_entry = '0;
         assign prev_cmp_gt    = 1'b0;
      end else begin : g_rest
         assign prev_cmp_entry = cell_cmp[k-1];
         assign prev_cmp_gt    = cell_cmp_gt[k-1];
      end

      swm_cell u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .old_value      (old_value),
         .valid          (cell_valid[k]),
         .next_entry     (next_entry),
         .next_gt        (next_gt),
         .prev_cmp_entry (prev_cmp_entry),
         .prev_cmp_gt    (prev_cmp_gt),
         .entry          (cell_entry[k]),
         .gt             (cell_gt[k]),
         .cmp_entry      (cell_cmp[k]),
         .cmp_gt         (cell_cmp_gt[k]),
         .oldest         (cell_oldest[k])
      );

      assign median_values[k] = cell_entry[k].value;
   end

   swm_median u_median (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid),
      .count      (fill_in),
      .values     (median_values),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always_comb begin
      sorted_ok[0] = 1'b1;
      newest[0]    = cell_valid[0] && (cell_entry[0].age == '0);
      for (int k = 1; k < swm_pkg::WINDOW_MAX; k++) begin
         sorted_ok[k] = !cell_valid[k] || (cell_entry[k-1].value <= cell_entry[k].value);
         newest[k]    = cell_valid[k] && (cell_entry[k].age == '0);
      end
   end

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      swm_pkg::CMP_WIDTH'(fill_ff) <= window_eff)
      else $error("fill count exceeds the window length");

   a_full_holds : assert property (@(posedge clock) disable iff (reset)
      accept && full && !csr_write |=> $stable(fill_ff))
      else $error("fill count changed on a full window");

   a_sorted : assert property (@(posedge clock) disable iff (reset)
      &sorted_ok)
      else $error("cell chain out of order");

   a_one_newest : assert property (@(posedge clock) disable iff (reset)
      accept && !csr_write |=> $onehot(newest))
      else $error("not exactly one newest entry after a transfer");

endmodule

FILE: bench/sliding_window_median_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window median unit testbench
// Streams signed samples through the unit under several window lengths and
// compares every median against a running sorted window kept in the bench.
// Both stream sides idle and stall at random, and the length register is
// rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module sliding_window_median_unit_tb;

   localparam logic [swm_pkg::ADDR_WIDTH-1:0] ADDR_WINDOW_LENGTH = 3'd0;
   localparam logic [swm_pkg::ADDR_WIDTH-1:0] ADDR_SPARE         = 3'd4;
   localparam int QUIET_LIMIT    = 5000;
   localparam int PHASE_SAMPLES  = 100;
   localparam int SETTLE_CYCLES  = 4;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_PERIODIC
   } stall_type;

   class median_tracker_type;
      logic signed [swm_pkg::SAMPLE_WIDTH-1:0] window_values [swm_pkg::WINDOW_MAX];
      int unsigned                    window_ages [swm_pkg::WINDOW_MAX];
      int unsigned                    held;
      logic [swm_pkg::LENGTH_WIDTH-1:0] length_setting;
      logic [swm_pkg::SAMPLE_WIDTH-1:0] expected_medians [$];
      int unsigned                    failures;

      function new();
         held = 0;
         length_setting = swm_pkg::LENGTH_RESET;
         failures = 0;
      endfunction

      function void load_length(logic [swm_pkg::LENGTH_WIDTH-1:0] value);
         length_setting = value;
         held = 0;
      endfunction

      function void note_sample(logic [swm_pkg::SAMPLE_WIDTH-1:0] raw);
         int unsigned span;
         int unsigned oldest;
         int unsigned pos;
         int unsigned i;
         int total;
         logic signed [swm_pkg::SAMPLE_WIDTH-1:0] s;
         logic [swm_pkg::SAMPLE_WIDTH-1:0] wanted;
         span = length_setting;
         if (span < 2) span = 2;
         if (span > swm_pkg::WINDOW_MAX) span = swm_pkg::WINDOW_MAX;
         s = raw;
         while (held >= span) begin
            oldest = 0;
            for (i = 1; i < held; i++)
               if (window_ages[i] > window_ages[oldest]) oldest = i;
            for (i = oldest; i + 1 < held; i++) begin
               window_values[i] = window_values[i+1];
               window_ages[i] = window_ages[i+1];
            end
            held--;
         end
         for (i = 0; i < held; i++) window_ages[i]++;
         pos = 0;
         while (pos < held && window_values[pos] <= s) pos++;
         for (i = held; i > pos; i--) begin
            window_values[i] = window_values[i-1];
            window_ages[i] = window_ages[i-1];
         end
         window_values[pos] = s;
         window_ages[pos] = 0;
         held++;
         if (held % 2 == 1) begin
            wanted = window_values[held/2];
         end else begin
            total = int'(window_values[held/2-1]) + int'(window_values[held/2]);
            wanted = swm_pkg::SAMPLE_WIDTH'(total / 2);
         end
         expected_medians = {expected_medians, wanted};
      endfunction

      function void check_median(logic [swm_pkg::SAMPLE_WIDTH-1:0] actual);
         logic [swm_pkg::SAMPLE_WIDTH-1:0] wanted;
         if (expected_medians.size() == 0) begin
            $error("median: expected none, actual %0d", $signed(actual));
            failures++;
         end else begin
            wanted = expected_medians.pop_front();
            if (actual !== wanted) begin
               $error("median: expected %0d, actual %0d", $signed(wanted), $signed(actual));
               failures++;
            end
         end
      endfunction

      function bit all_matched();
         if (expected_medians.size() != 0) begin
            $error("median: expected %0d more, actual none", expected_medians.size());
            failures++;
         end
         return failures == 0;
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [swm_pkg::SAMPLE_WIDTH-1:0] req_tdata = '0;      // [15:0] sample
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [swm_pkg::SAMPLE_WIDTH-1:0] rsp_tdata;           // [15:0] median
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [swm_pkg::ADDR_WIDTH-1:0]   csr_paddr = '0;
   logic [swm_pkg::DATA_WIDTH-1:0]   csr_pwdata = '0;
   logic [swm_pkg::DATA_WIDTH-1:0]   csr_prdata;
   logic                    csr_pready;

   median_tracker_type      board;
   logic [swm_pkg::SAMPLE_WIDTH-1:0] pending_samples [$];
   stall_type               stall_pattern = READY_ALWAYS;
   int unsigned             pattern_left = 0;
   int unsigned             cycle_count = 0;
   int unsigned             quiet_cycles = 0;

   sliding_window_median_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   wire sample_transfer = req_tvalid && req_tready;
   wire median_transfer = rsp_tvalid && rsp_tready;
   wire csr_transfer    = csr_psel && csr_penable && csr_pready;

   always @(posedge clock) begin
      if (!reset) begin
         if (sample_transfer) board.note_sample(req_tdata);
         if (median_transfer) board.check_median(rsp_tdata);
         if (csr_transfer && csr_pwrite && csr_paddr[2] == swm_pkg::REG_WINDOW_LENGTH)
            board.load_length(csr_pwdata[swm_pkg::LENGTH_WIDTH-1:0]);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (pattern_left == 0) begin
         stall_pattern <= stall_type'($urandom_range(0, 3));
         pattern_left <= $urandom_range(20, 200);
      end else begin
         pattern_left <= pattern_left - 1;
      end
      case (stall_pattern)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_RANDOM:   rsp_tready <= $urandom_range(0, 1);
         READY_SPARSE:   rsp_tready <= ($urandom_range(0, 4) == 0);
         READY_PERIODIC: rsp_tready <= (cycle_count % 7 < 3);
         default:        rsp_tready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (reset || sample_transfer || median_transfer || csr_transfer) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[sliding_window_median_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [swm_pkg::SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1, 2:    return swm_pkg::SAMPLE_WIDTH'(int'($urandom_range(0, 6)) - 3);
         default: return swm_pkg::SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   task automatic stream_pending();
      int burst;
      int gap;
      while (pending_samples.size() != 0) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && pending_samples.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_samples.pop_front();
            do @(posedge clock); while (!req_tready);
            burst--;
         end
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (board.expected_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [swm_pkg::ADDR_WIDTH-1:0] addr,
                                 logic [swm_pkg::LENGTH_WIDTH-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_length_readback(logic [swm_pkg::LENGTH_WIDTH-1:0] value);
      logic [swm_pkg::DATA_WIDTH-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_WINDOW_LENGTH;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== swm_pkg::DATA_WIDTH'(value)) begin
         $error("window_length: expected %0d, actual %0d", value, readback);
         board.failures++;
      end
   endtask

   initial begin
      int phase_lengths [12];
      int half;
      board = new();
      phase_lengths = '{0, 1, 2, 3, 64, 127, 65, 4, 0, 0, 0, 0};
      for (int p = 8; p < 12; p++)
         phase_lengths[p] = (p == 11) ? $urandom_range(65, 127) : $urandom_range(2, 64);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The window starts at its reset length of five; equal samples and
      // even counts at both ends of the range come first.
      pending_samples = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
                          16'h0001, 16'h0001, 16'h0001, 16'h8000, 16'h8001, 16'h7FFF,
                          16'h0005, 16'h0005, 16'h0005, 16'h0064, 16'hFF9C};
      stream_pending();
      wait_idle();

      // A write to an unused address must leave the window untouched.
      write_register(ADDR_SPARE, 7'd3);
      pending_samples = '{16'h1234, 16'hEDCC, 16'h0000};
      stream_pending();
      wait_idle();

      foreach (phase_lengths[p]) begin
         write_register(ADDR_WINDOW_LENGTH, swm_pkg::LENGTH_WIDTH'(phase_lengths[p]));
         check_length_readback(swm_pkg::LENGTH_WIDTH'(phase_lengths[p]));
         if (p == 0) begin
            // Negative even sums must round toward zero, not down.
            pending_samples = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFE};
         end
         for (int k = 0; k < PHASE_SAMPLES; k++)
            pending_samples = {pending_samples, random_sample()};
         half = $urandom_range(10, PHASE_SAMPLES - 10);
         while (pending_samples.size() > PHASE_SAMPLES - half) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_samples.pop_front();
            do @(posedge clock); while (!req_tready);
         end
         req_tvalid <= 1'b0;
         wait_idle();
         stream_pending();
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (board.all_matched())
         $display("[sliding_window_median_unit] OK");
      else
         $display("[sliding_window_median_unit] ERROR");
      $finish;
   end

endmodule

FILE: sliding_window_median_unit.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_median.sv
rtl/sliding_window_median_unit.sv
bench/sliding_window_median_unit_tb.sv
